// File: hdl/tgi_pkg.sv
package tgi_pkg;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // One in Q1.16, and the same value widened for sums of two fractions.
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [17:0] ONE_Q16_W   = 18'h10000;
    localparam logic [34:0] ROUND_HALF  = 35'h0_0000_8000;

    typedef struct packed {
        logic [16:0] w2;
        logic [16:0] w1;
        logic [16:0] w0;
    } weights_t;

    typedef struct packed {
        logic [15:0] c3;
        logic [15:0] c2;
        logic [15:0] c1;
        logic [15:0] c0;
    } sample_t;

endpackage

// File: hdl/tgi_coord.sv
module tgi_coord #(
    parameter int MAX_ORDER = 31,
    parameter int AW        = 10
) (
    input  logic              clk,
    input  logic [2:0]        en,
    input  logic [4:0]        order,
    input  logic [16:0]       coord_u,
    input  logic [16:0]       coord_v,
    output logic [AW-1:0]     idx0,
    output logic [AW-1:0]     idx1,
    output logic [AW-1:0]     idx2,
    output tgi_pkg::weights_t weights,
    output logic              range_err
);

    localparam int OW = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
    localparam int NW = OW + 17;
    localparam int IW = 2 * OW + 3;

    logic [8:0]    order_x;
    logic [8:0]    ord9;
    logic [OW-1:0] ord;

    logic [NW-1:0] nu_reg;
    logic [NW-1:0] nv_reg;
    logic          err1_reg;

    logic [OW-1:0] cu;
    logic [OW-1:0] cv;
    logic [16:0]   fu;
    logic [16:0]   fv;
    logic [17:0]   sw;

    logic [OW-1:0] cu2_reg;
    logic [OW-1:0] cv2_reg;
    logic [16:0]   fu2_reg;
    logic [16:0]   fv2_reg;
    logic [17:0]   sw2_reg;
    logic          up2_reg;
    logic          err2_reg;

    logic [IW-1:0] d;
    logic [IW-1:0] tri_n;
    logic [IW-1:0] base;
    logic [IW-1:0] i0;
    logic [IW-1:0] i1;
    logic [IW-1:0] i2;
    tgi_pkg::weights_t w;

    // An order of zero acts as one; an order above the table acts as the largest.
    assign order_x = {4'b0, order};

    always_comb
    begin
        if (order_x == 9'd0)
            ord9 = 9'd1;
        else if (order_x > 9'(MAX_ORDER))
            ord9 = 9'(MAX_ORDER);
        else
            ord9 = order_x;
    end

    assign ord = ord9[OW-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            nu_reg   <= NW'(ord) * NW'(coord_u);
            nv_reg   <= NW'(ord) * NW'(coord_v);
            err1_reg <= ({1'b0, coord_u} + {1'b0, coord_v}) > tgi_pkg::ONE_Q16_W;
        end
    end

    // On the far edge both fractions are zero; step one cell back with fraction one.
    always_comb
    begin
        cu = nu_reg[16 +: OW];
        cv = nv_reg[16 +: OW];
        fu = {1'b0, nu_reg[15:0]};
        fv = {1'b0, nv_reg[15:0]};
        if (({1'b0, cu} + {1'b0, cv}) >= {1'b0, ord})
        begin
            if (cu != '0)
            begin
                cu = cu - OW'(1);
                fu = tgi_pkg::ONE_Q16;
            end
            else if (cv != '0)
            begin
                cv = cv - OW'(1);
                fv = tgi_pkg::ONE_Q16;
            end
        end
        sw = {1'b0, fu} + {1'b0, fv};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cu2_reg  <= cu;
            cv2_reg  <= cv;
            fu2_reg  <= fu;
            fv2_reg  <= fv;
            sw2_reg  <= sw;
            up2_reg  <= sw > tgi_pkg::ONE_Q16_W;
            err2_reg <= err1_reg;
        end
    end

    // The upper half-cell uses the node of the next diagonal as its base.
    always_comb
    begin
        d     = IW'(cu2_reg) + IW'(cv2_reg) + IW'(up2_reg);
        tri_n = (d * (d + IW'(1))) >> 1;
        base  = tri_n + IW'(cv2_reg);
        if (up2_reg)
        begin
            i0   = base + IW'(1);
            i1   = base;
            i2   = base + d + IW'(2);
            w.w0 = tgi_pkg::ONE_Q16 - fu2_reg;
            w.w1 = tgi_pkg::ONE_Q16 - fv2_reg;
            w.w2 = 17'(sw2_reg - tgi_pkg::ONE_Q16_W);
        end
        else
        begin
            i0   = base + d + IW'(1);
            i1   = base + d + IW'(2);
            i2   = base;
            w.w0 = fu2_reg;
            w.w1 = fv2_reg;
            w.w2 = 17'(tgi_pkg::ONE_Q16_W - sw2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            idx0      <= i0[AW-1:0];
            idx1      <= i1[AW-1:0];
            idx2      <= i2[AW-1:0];
            weights   <= w;
            range_err <= err2_reg;
        end
    end

endmodule

// File: hdl/tgi_mem.sv
module tgi_mem #(
    parameter int DEPTH = 528,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  tgi_pkg::sample_t wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    input  logic [AW-1:0]    raddr2,
    output tgi_pkg::sample_t q0,
    output tgi_pkg::sample_t q1,
    output tgi_pkg::sample_t q2
);

    // Three copies written together give three corner reads per cycle while re is high.
    tgi_pkg::sample_t mem0 [DEPTH];
    tgi_pkg::sample_t mem1 [DEPTH];
    tgi_pkg::sample_t mem2 [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem0[waddr] <= wdata;
            mem1[waddr] <= wdata;
            mem2[waddr] <= wdata;
        end
        if (re)
        begin
            q0 <= mem0[raddr0];
            q1 <= mem1[raddr1];
            q2 <= mem2[raddr2];
        end
    end

endmodule

// File: hdl/tgi_blend.sv
module tgi_blend #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic              clk,
    input  logic [1:0]        en,
    input  tgi_pkg::weights_t weights,
    input  tgi_pkg::sample_t  s0,
    input  tgi_pkg::sample_t  s1,
    input  tgi_pkg::sample_t  s2,
    input  logic              range_err,
    output tgi_pkg::sample_t  result
);

    localparam logic [18:0] COMP_MAX = 19'((1 << COMPONENT_BITS) - 1);

    logic [16:0] wv   [3];
    logic [15:0] comp [3][4];
    logic [32:0] prod_reg [3][4];
    logic        err5_reg;
    logic [15:0] res  [4];

    always_comb
    begin
        wv[0] = weights.w0;
        wv[1] = weights.w1;
        wv[2] = weights.w2;
        comp[0][0] = s0.c0; comp[0][1] = s0.c1; comp[0][2] = s0.c2; comp[0][3] = s0.c3;
        comp[1][0] = s1.c0; comp[1][1] = s1.c1; comp[1][2] = s1.c2; comp[1][3] = s1.c3;
        comp[2][0] = s2.c0; comp[2][1] = s2.c1; comp[2][2] = s2.c2; comp[2][3] = s2.c3;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prod_reg[j][k] <= 33'(wv[j]) * 33'(comp[j][k]);
                end
            end
            err5_reg <= range_err;
        end
    end

    // Round half up, then saturate; an out-of-range query returns zero.
    always_comb
    begin
        logic [34:0] acc;
        logic [18:0] r;
        for (int k = 0; k < 4; k++)
        begin
            acc = 35'(prod_reg[0][k]) + 35'(prod_reg[1][k]) + 35'(prod_reg[2][k])
                + tgi_pkg::ROUND_HALF;
            r   = acc[34:16];
            if (err5_reg)
                res[k] = '0;
            else if (r > COMP_MAX)
                res[k] = COMP_MAX[15:0];
            else
                res[k] = r[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            result.c0 <= res[0];
            result.c1 <= res[1];
            result.c2 <= res[2];
            result.c3 <= res[3];
        end
    end

endmodule

// File: hdl/triangle_grid_interpolator.sv
// Channel   Direction  Contents
// s_axis    in         tuser: kind; tdata: entry_index, load_c0..3, coord_u, coord_v
// m_axis    out        tuser: range_error; tdata: out_c0..3
// cfg       in         cfg_we / cfg_wdata write grid_order
//
// One item enters per cycle while s_tready is high; a query result passes the
// stages order multiply, cell select, index/weight, table read, products, and
// sum and round. A load writes the table in the read stage and gives no result.
// Reset clears the stage valid bits and sets grid_order to one; the sample
// table is not cleared. Each stage holds its item when the next one is full
// and stalled, so bubbles close up and nothing is lost or repeated.
module triangle_grid_interpolator #(
    parameter int MAX_ORDER      = 31,
    parameter int COMPONENT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // entry_index, load_c0, load_c1, load_c2, load_c3,
                                   // coord_u, coord_v, zero fill
    input  logic         s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // out_c0, out_c1, out_c2, out_c3
    output logic         m_tuser,  // range_error
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata
);

    localparam int DEPTH = ((MAX_ORDER + 1) * (MAX_ORDER + 2)) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [15:0] COMP_MASK = 16'((1 << COMPONENT_BITS) - 1);

    logic [4:0] order_reg;

    // Per-stage valid bits and the ready chain from the output back.
    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic [5:0] rdy;

    logic             kind1_reg, kind2_reg, kind3_reg, kind4_reg;
    logic [9:0]       idx1_reg, idx2_reg, idx3_reg;
    tgi_pkg::sample_t data1_reg, data2_reg, data3_reg;
    tgi_pkg::sample_t load_data;

    logic [AW-1:0]     ci0, ci1, ci2;
    tgi_pkg::weights_t cw;
    logic              cerr;
    tgi_pkg::weights_t w4_reg;
    logic              err4_reg;
    logic              err5_reg;
    logic              mem_we;
    tgi_pkg::sample_t  q0, q1, q2;
    tgi_pkg::sample_t  result;
    logic              err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 5'd1;
        else if (cfg_we)
            order_reg <= cfg_wdata;
    end

    always_comb
    begin
        rdy[5] = !vld_reg[5] || m_tready;
        for (int k = 4; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    // Loads leave the pipeline once they have written the table.
    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0]) vld_next[0] = s_tvalid;
        if (rdy[1]) vld_next[1] = vld_reg[0];
        if (rdy[2]) vld_next[2] = vld_reg[1];
        if (rdy[3]) vld_next[3] = vld_reg[2];
        if (rdy[4]) vld_next[4] = vld_reg[3] && (kind4_reg == tgi_pkg::KIND_QUERY);
        if (rdy[5]) vld_next[5] = vld_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = rdy[0];

    assign load_data.c0 = s_tdata[25:10]  & COMP_MASK;
    assign load_data.c1 = s_tdata[41:26]  & COMP_MASK;
    assign load_data.c2 = s_tdata[57:42]  & COMP_MASK;
    assign load_data.c3 = s_tdata[73:58]  & COMP_MASK;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            kind1_reg <= s_tuser;
            idx1_reg  <= s_tdata[9:0];
            data1_reg <= load_data;
        end
        if (rdy[1])
        begin
            kind2_reg <= kind1_reg;
            idx2_reg  <= idx1_reg;
            data2_reg <= data1_reg;
        end
        if (rdy[2])
        begin
            kind3_reg <= kind2_reg;
            idx3_reg  <= idx2_reg;
            data3_reg <= data2_reg;
        end
        if (rdy[3])
        begin
            kind4_reg <= kind3_reg;
            w4_reg    <= cw;
            err4_reg  <= cerr;
        end
        if (rdy[5])
            err_out_reg <= err5_reg;
    end

    // The range flag rides beside the blend stages.
    always_ff @(posedge clk)
    begin
        if (rdy[4])
            err5_reg <= err4_reg;
    end

    tgi_coord #(
        .MAX_ORDER (MAX_ORDER),
        .AW        (AW)
    ) u_coord (
        .clk       (clk),
        .en        (rdy[2:0]),
        .order     (order_reg),
        .coord_u   (s_tdata[90:74]),
        .coord_v   (s_tdata[107:91]),
        .idx0      (ci0),
        .idx1      (ci1),
        .idx2      (ci2),
        .weights   (cw),
        .range_err (cerr)
    );

    // A load beyond the table is dropped.
    assign mem_we = rdy[3] && vld_reg[2] && (kind3_reg == tgi_pkg::KIND_LOAD)
                 && ({1'b0, idx3_reg} < 11'(DEPTH));

    tgi_mem #(
        .DEPTH  (DEPTH),
        .AW     (AW)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (idx3_reg[AW-1:0]),
        .wdata  (data3_reg),
        .re     (rdy[3]),
        .raddr0 (ci0),
        .raddr1 (ci1),
        .raddr2 (ci2),
        .q0     (q0),
        .q1     (q1),
        .q2     (q2)
    );

    tgi_blend #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_blend (
        .clk       (clk),
        .en        (rdy[5:4]),
        .weights   (w4_reg),
        .s0        (q0),
        .s1        (q1),
        .s2        (q2),
        .range_err (err4_reg),
        .result    (result)
    );

    assign m_tvalid = vld_reg[5];
    assign m_tdata  = result;
    assign m_tuser  = err_out_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("range error result carries nonzero components");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> vld_reg[0])
        else $error("input stalled with empty first stage");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !rdy[0] |=> vld_reg[0])
        else $error("stalled first stage lost its item");
`endif

endmodule
